FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SAMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SAMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/sams_pkg.sv
`timescale 1ns / 1ps

package sams_pkg;

	localparam int NUM_STACKS_DEF = 4;
	localparam int MEM_DEPTH_DEF  = 64;

	localparam int KEY_W   = 32;
	localparam int INDEX_W = 2;
	localparam int COUNT_W = 7;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POP_WAIT,
		ST_RSCAN,
		ST_LCHECK,
		ST_LSCAN,
		ST_COPY,
		ST_FINISH
	} state_t;

endpackage

FILE: src/sams_ram.sv
`timescale 1ns / 1ps

module sams_ram import sams_pkg::*; #(
	parameter int DEPTH = MEM_DEPTH_DEF,
	parameter int AW    = $clog2(MEM_DEPTH_DEF),
	parameter int DW    = KEY_W
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/shared_array_multi_stack_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tuser: opcode; tdata: stack_index, key_in
// m_axis    out  tuser: ok; tdata: key_out, count
//
// A pop reads the top record of its stack into the output register; a pop of an
// empty stack loads a result with no read, and a push that finds room writes its key
// at the top. A push onto a full stack first repacks the record memory one record
// per cycle, moving neighbouring stacks into free room, then pushes if room was made.
// Reset sets the marks to equal empty regions at once; the record memory is not
// cleared. A waiting result only holds the block when a second result is ready.

module shared_array_multi_stack_unit import sams_pkg::*; #(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int MEM_DEPTH  = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // stack_index[1:0], key_in[33:2], zero pad
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // key_out[31:0], count[38:32], zero pad
	output logic        m_axis_tuser   // ok
);

`include "assert_macros.svh"

	localparam int AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int MW     = $clog2(MEM_DEPTH + 1);
	localparam int SW     = $clog2(NUM_STACKS + 1);
	localparam int REGION = MEM_DEPTH / NUM_STACKS;

	// Marks are held offset by one: a stack owns slots bottom_q to top_q - 1.
	logic [MW-1:0] top_q    [NUM_STACKS+1];
	logic [MW-1:0] bottom_q [NUM_STACKS+1];

	state_t state_q, state_d;

	logic               op_q;
	logic [INDEX_W-1:0] k_q;
	logic [KEY_W-1:0]   key_q;
	logic [SW-1:0]      j_q;
	logic [MW-1:0]      src_q;
	logic [MW-1:0]      rem_q;
	logic               dir_right_q;
	logic               v_s1;
	logic [MW-1:0]      a_s1;

	logic               out_valid_q;
	logic               out_ok_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic [SW-1:0] k_idx;
	logic [MW-1:0] tk, bk, bk1, tj, bj, bj1, tjm;
	logic          k_valid, full_k, res_free;
	logic          res_load, res_ok;
	logic [KEY_W-1:0]   res_key;
	logic [COUNT_W-1:0] res_cnt;

	logic             rd_en, wr_en, copy_wr, push_wr;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [KEY_W-1:0] rd_data, wr_data;
	logic [MW-1:0]    copy_wr_addr;

	assign k_idx   = SW'(k_q);
	assign k_valid = int'(k_q) < NUM_STACKS;
	assign tk      = top_q[k_idx];
	assign bk      = bottom_q[k_idx];
	assign bk1     = bottom_q[k_idx + SW'(1)];
	assign tj      = top_q[j_q];
	assign bj      = bottom_q[j_q];
	assign bj1     = bottom_q[j_q + SW'(1)];
	assign tjm     = top_q[j_q - SW'(1)];
	assign full_k  = tk == bk1;
	assign res_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = state_q == ST_IDLE;

	// Copy pipeline: the record read in one cycle is written one slot over in the next.
	assign copy_wr      = v_s1;
	assign copy_wr_addr = dir_right_q ? a_s1 + MW'(1) : a_s1 - MW'(1);
	assign push_wr      = state_q == ST_FINISH && res_free && !full_k;
	assign wr_en        = copy_wr || push_wr;
	assign wr_addr      = copy_wr ? copy_wr_addr[AW-1:0] : tk[AW-1:0];
	assign wr_data      = copy_wr ? rd_data : key_q;

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = src_q[AW-1:0];
		res_load = 1'b0;
		res_ok   = 1'b0;
		res_key  = '0;
		res_cnt  = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!k_valid) begin
					if (res_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (op_q == OP_POP) begin
					if (tk != bk) begin
						rd_en   = 1'b1;
						rd_addr = tk[AW-1:0] - AW'(1);
						state_d = ST_POP_WAIT;
					end else if (res_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (full_k && int'(k_q) < NUM_STACKS - 1) begin
					state_d = ST_RSCAN;
				end else begin
					state_d = ST_LCHECK;
				end
			end
			ST_POP_WAIT: begin
				if (res_free) begin
					res_load = 1'b1;
					res_ok   = 1'b1;
					res_key  = rd_data;
					res_cnt  = COUNT_W'(tk - bk);
					state_d  = ST_IDLE;
				end
			end
			ST_RSCAN: begin
				if (j_q == k_idx) begin
					state_d = ST_LCHECK;
				end else if (tj < bj1) begin
					state_d = ST_COPY;
				end
			end
			ST_LCHECK: begin
				state_d = (full_k && k_q != '0) ? ST_LSCAN : ST_FINISH;
			end
			ST_LSCAN: begin
				if (j_q > k_idx) begin
					state_d = ST_FINISH;
				end else if (tjm < bj) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (rem_q != '0) begin
					rd_en = 1'b1;
				end else if (!v_s1) begin
					state_d = dir_right_q ? ST_RSCAN : ST_LSCAN;
				end
			end
			ST_FINISH: begin
				if (res_free) begin
					res_load = 1'b1;
					res_ok   = !full_k;
					res_cnt  = COUNT_W'(tk - bk + MW'(!full_k));
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUM_STACKS; i++) begin
				top_q[i]    <= MW'(i * REGION);
				bottom_q[i] <= MW'(i * REGION);
			end
			j_q  <= '0;
			rem_q <= '0;
			v_s1 <= 1'b0;
			a_s1 <= '0;
			src_q <= '0;
			dir_right_q <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_COPY && rem_q != '0;
			a_s1 <= src_q;
			case (state_q)
				ST_DISPATCH: begin
					if (k_valid && op_q == OP_POP && tk != bk) begin
						top_q[k_idx] <= tk - MW'(1);
					end
					j_q <= SW'(NUM_STACKS - 1);
				end
				ST_RSCAN: begin
					if (j_q != k_idx) begin
						if (tj < bj1) begin
							src_q       <= tj - MW'(1);
							rem_q       <= tj - bj;
							dir_right_q <= 1'b1;
						end else begin
							j_q <= j_q - SW'(1);
						end
					end
				end
				ST_LCHECK: begin
					j_q <= SW'(1);
				end
				ST_LSCAN: begin
					if (j_q <= k_idx) begin
						if (tjm < bj) begin
							src_q       <= bj;
							rem_q       <= tj - bj;
							dir_right_q <= 1'b0;
						end else begin
							j_q <= j_q + SW'(1);
						end
					end
				end
				ST_COPY: begin
					if (rem_q != '0) begin
						src_q <= dir_right_q ? src_q - MW'(1) : src_q + MW'(1);
						rem_q <= rem_q - MW'(1);
					end else if (!v_s1) begin
						if (dir_right_q) begin
							top_q[j_q]    <= tj + MW'(1);
							bottom_q[j_q] <= bj + MW'(1);
							j_q           <= j_q - SW'(1);
						end else begin
							top_q[j_q]    <= tj - MW'(1);
							bottom_q[j_q] <= bj - MW'(1);
							j_q           <= j_q + SW'(1);
						end
					end
				end
				ST_FINISH: begin
					if (push_wr) begin
						top_q[k_idx] <= tk + MW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			op_q  <= s_axis_tuser;
			k_q   <= s_axis_tdata[INDEX_W-1:0];
			key_q <= s_axis_tdata[INDEX_W+KEY_W-1:INDEX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_ok_q  <= res_ok;
			out_key_q <= res_key;
			out_cnt_q <= res_cnt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tdata  = {1'b0, out_cnt_q, out_key_q};

	sams_ram #(
		.DEPTH (MEM_DEPTH),
		.AW    (AW),
		.DW    (KEY_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	`SAMS_ASSERT(a_limit_top, top_q[NUM_STACKS] == MW'(NUM_STACKS * REGION), "limit top moved")
	`SAMS_ASSERT(a_limit_bot, bottom_q[NUM_STACKS] == MW'(NUM_STACKS * REGION), "limit base moved")
	`SAMS_ASSERT(a_one_writer, !(copy_wr && push_wr), "copy write and push write together")
	`SAMS_ASSERT(a_target_order, (state_q == ST_FINISH) |-> (tk >= bk && tk <= bk1), "marks out of order")

endmodule
